// ----- hw/rtl/ccfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfd_pkg: shared types and constants for the CRC-checked frame deframer
// Holds the header layout, the status codes, the CRC-32 table and the
// result word that travels from the front end to the output queue.
// ----------------------------------------------------------------------------
package ccfd_pkg;

    // Header layout, big-endian byte offsets
    localparam int unsigned HDR_BYTES    = 28;
    localparam int unsigned HDR_IDX_W    = 5;
    localparam int unsigned OFS_MAGIC0   = 0;
    localparam int unsigned OFS_MAGIC1   = 1;
    localparam int unsigned OFS_VERSION  = 2;
    localparam int unsigned OFS_FLAGS    = 4;
    localparam int unsigned OFS_KIND     = 8;
    localparam int unsigned OFS_NUMBER   = 10;
    localparam int unsigned OFS_CONTENT  = 14;
    localparam int unsigned OFS_COMP     = 15;
    localparam int unsigned OFS_CRC      = 20;
    localparam int unsigned OFS_LENGTH   = 24;

    // Register reset values
    localparam logic [7:0] MAGIC_FIRST_RST  = 8'h4D;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'h55;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOUT = 32'hFFFFFFFF;

    // Output queue depth default
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAGIC_FIRST  = 2'd0,
        CFG_MAGIC_SECOND = 2'd1,
        CFG_STRICT_FLAG  = 2'd2
    } t_cfg_index;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CRC      = 3'd4,
        ST_FLAG     = 3'd5,
        ST_COMP     = 3'd6
    } t_status;

    // Compressed flag values
    localparam logic [7:0] COMP_NONE = 8'd0;
    localparam logic [7:0] COMP_ON   = 8'd1;

    // One result word
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        logic [2:0]  frame_status;
        logic [15:0] msg_kind;
        logic [31:0] msg_number;
        logic [15:0] hdr_version;
        logic [31:0] hdr_flags;
        logic [7:0]  hdr_content;
    } t_result;

    // Queue occupancy flags seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef logic [31:0] t_crc_table [256];

    // Byte-wise CRC table, built at elaboration
    function automatic t_crc_table crc_table_gen();
        t_crc_table tab;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_table CRC_TABLE = crc_table_gen();

endpackage

// ----- hw/rtl/ccfd_front.sv -----
// ----------------------------------------------------------------------------
// ccfd_front: byte intake, header capture, CRC and frame check
// Counts bytes, stores the header, runs the payload through the CRC and
// builds a finished result word for every payload or final byte.
// ----------------------------------------------------------------------------
module ccfd_front
    import ccfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Incoming word
    input  logic        i_in_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // Result word to the queue
    output logic        o_push,
    output t_result     o_result
);

    logic [7:0]  r_magic_first;
    logic [7:0]  r_magic_second;
    logic        r_strict;
    logic [31:0] r_count;
    logic [31:0] r_crc;
    logic [7:0]  r_hdr [HDR_BYTES];

    logic [31:0] n_count;
    logic [31:0] n_crc;
    logic [7:0]  n_hdr [HDR_BYTES];
    logic        is_payload;
    logic        hdr_wr;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [7:0]  crc_idx;
    logic [31:0] len_field;
    logic [31:0] crc_field;
    logic [31:0] crc_final;
    logic [7:0]  comp;
    logic [2:0]  status;

    // Configuration registers; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first  <= MAGIC_FIRST_RST;
            r_magic_second <= MAGIC_SECOND_RST;
            r_strict       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAGIC_FIRST:  r_magic_first  <= i_cfg_data;
                CFG_MAGIC_SECOND: r_magic_second <= i_cfg_data;
                CFG_STRICT_FLAG:  r_strict       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the word and work out the next counter and CRC
    assign is_payload = (r_count >= 32'(HDR_BYTES));
    assign hdr_wr     = !is_payload;
    assign hdr_idx    = r_count[HDR_IDX_W-1:0];
    assign crc_idx    = r_crc[7:0] ^ i_in_byte;

    always_comb begin
        n_count = (r_count == '1) ? r_count : r_count + 32'd1;
        n_crc   = is_payload ? (CRC_TABLE[crc_idx] ^ (r_crc >> 8)) : r_crc;
    end

    // Header view including the byte that arrives this cycle
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            n_hdr[i] = (hdr_wr && (hdr_idx == HDR_IDX_W'(i))) ? i_in_byte : r_hdr[i];
        end
    end

    assign len_field = {n_hdr[OFS_LENGTH], n_hdr[OFS_LENGTH+1],
                        n_hdr[OFS_LENGTH+2], n_hdr[OFS_LENGTH+3]};
    assign crc_field = {n_hdr[OFS_CRC], n_hdr[OFS_CRC+1],
                        n_hdr[OFS_CRC+2], n_hdr[OFS_CRC+3]};
    assign crc_final = n_crc ^ CRC_XOUT;
    assign comp      = n_hdr[OFS_COMP];

    // Frame status in priority order
    always_comb begin
        if (n_count < 32'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (n_hdr[OFS_MAGIC0] != r_magic_first ||
                     n_hdr[OFS_MAGIC1] != r_magic_second) begin
            status = ST_MAGIC;
        end else if (n_count == '1 || (n_count - 32'(HDR_BYTES)) != len_field) begin
            status = ST_LENGTH;
        end else if (crc_final != crc_field) begin
            status = ST_CRC;
        end else if (r_strict && comp > COMP_ON) begin
            status = ST_FLAG;
        end else if (comp == COMP_ON) begin
            status = ST_COMP;
        end else begin
            status = ST_OK;
        end
    end

    // Result word; header fields are shown only on a final word that completes the header
    always_comb begin
        o_result = '0;
        o_push   = i_in_accept && (is_payload || i_in_last);
        if (is_payload) begin
            o_result.payload_byte  = i_in_byte;
            o_result.payload_valid = 1'b1;
        end
        if (i_in_last) begin
            o_result.frame_done   = 1'b1;
            o_result.frame_status = status;
            if (status != ST_SHORT) begin
                o_result.msg_kind    = {n_hdr[OFS_KIND], n_hdr[OFS_KIND+1]};
                o_result.msg_number  = {n_hdr[OFS_NUMBER], n_hdr[OFS_NUMBER+1],
                                        n_hdr[OFS_NUMBER+2], n_hdr[OFS_NUMBER+3]};
                o_result.hdr_version = {n_hdr[OFS_VERSION], n_hdr[OFS_VERSION+1]};
                o_result.hdr_flags   = {n_hdr[OFS_FLAGS], n_hdr[OFS_FLAGS+1],
                                        n_hdr[OFS_FLAGS+2], n_hdr[OFS_FLAGS+3]};
                o_result.hdr_content = n_hdr[OFS_CONTENT];
            end
        end
    end

    // Counter and CRC return to their start values after the final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (i_in_accept) begin
            r_count <= i_in_last ? '0 : n_count;
            r_crc   <= i_in_last ? CRC_INIT : n_crc;
        end
    end

    // Header store, written one byte per header word
    always_ff @(posedge i_clk) begin
        if (i_in_accept && hdr_wr) begin
            r_hdr[hdr_idx] <= i_in_byte;
        end
    end

endmodule

// ----- hw/rtl/ccfd_back.sv -----
// ----------------------------------------------------------------------------
// ccfd_back: result queue and output side
// A short circular queue of finished result words that presents its head
// on the output stream and lets the front end keep taking bytes.
// ----------------------------------------------------------------------------
module ccfd_back
    import ccfd_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_result,
    input  logic          i_pop,
    output t_result       o_head,
    output t_queue_status o_status
);

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    t_result          r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntW-1:0]  r_level;

    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_level == CntW'(QueueDepth));
    assign o_status.empty = (r_level == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrW'(QueueDepth - 1)) ? '0 : r_wptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrW'(QueueDepth - 1)) ? '0 : r_rptr + PtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_level <= r_level + CntW'(1);
                2'b01:   r_level <= r_level - CntW'(1);
                default: r_level <= r_level;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

endmodule

// ----- hw/rtl/crc_checked_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer: header parse and CRC-32 check of byte frames
// A result word is built combinationally and registered in the result queue, which offers it.
// Throughput: one byte per cycle; the front end does the table CRC step and
// the frame checks in that cycle, and the result queue decouples the output.
// Input ready drops only while the result queue is full.
// Reset (synchronous, active low) clears the counter, CRC, queue and the
// configuration registers to their defaults; the header store is not cleared.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer
    import ccfd_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    // Byte stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
    input  logic         s_axis_tlast,   // frame_last
    // Result stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] payload_byte, [10:8] frame_status, [26:11] msg_kind,
    // [58:27] msg_number, [74:59] hdr_version, [106:75] hdr_flags,
    // [114:107] hdr_content, [119:115] zero
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tlast,   // frame_done
    output logic         m_axis_tuser    // payload_valid
);

    logic          in_accept;
    logic          push;
    t_result       result;
    t_result       head;
    t_queue_status q_status;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Front end: intake and checks
    ccfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (in_accept),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_push      (push),
        .o_result    (result)
    );

    // Back end: result queue
    ccfd_back #(
        .QueueDepth (QueueDepth)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .i_pop    (m_axis_tready),
        .o_head   (head),
        .o_status (q_status)
    );

    // Output packing
    assign m_axis_tvalid = !q_status.empty;
    assign m_axis_tlast  = head.frame_done;
    assign m_axis_tuser  = head.payload_valid;
    assign m_axis_tdata  = {5'b0, head.hdr_content, head.hdr_flags, head.hdr_version,
                            head.msg_number, head.msg_kind, head.frame_status,
                            head.payload_byte};

`ifndef SYNTHESIS
    // Queue can never be both full and empty
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // A final byte always leaves a result waiting in the next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("final byte produced no result");

    // Every result is a payload word or a frame end
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result is neither payload nor frame end");

    // Status is zero except on a frame end
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:8] == ST_OK))
        else $error("status set on a payload-only result");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for crc_checked_frame_deframer
// Builds byte frames with a 28-byte big-endian header and a CRC-32 protected
// payload, drives them with random gaps, and checks every result word against
// a cycle-free predictor of the deframer. Directed frames hit each status
// code and the field extremes; random traffic then runs under changing
// register settings, with random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    import ccfd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1950;
    localparam int unsigned CLK_HALF_NS = 4;
    localparam int unsigned MAX_GAP = 11;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_PRINTED = 200;
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum int {
        FK_GOOD, FK_COMP_ON, FK_COMP_ODD, FK_MAGIC, FK_LENGTH, FK_CRC, FK_SHORT, FK_NOISE
    } t_frame_kind;

    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } t_fill;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [7:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;

    // Predictor state: register copies, header bytes, counter and running CRC.
    logic [7:0]   want_magic0;
    logic [7:0]   want_magic1;
    logic         want_strict;
    logic [7:0]   hdr_seen [HDR_BYTES];
    logic [31:0]  byte_count;
    logic [31:0]  crc_run;

    t_result      pending_results [$];
    logic [7:0]   frame_q [$];
    int unsigned  items_sent;
    int unsigned  mismatch_count;
    bit           tx_fast;
    bit           rx_fast;

    crc_checked_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // The run is cut off well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("ERROR: simulation timeout");
        $display("** crc_checked_frame_deframer: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // One bit-serial step of the reflected CRC-32.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] hdr_be16(input int unsigned ofs);
        return {hdr_seen[ofs], hdr_seen[ofs + 1]};
    endfunction

    function automatic logic [31:0] hdr_be32(input int unsigned ofs);
        return {hdr_seen[ofs], hdr_seen[ofs + 1], hdr_seen[ofs + 2], hdr_seen[ofs + 3]};
    endfunction

    task automatic reset_predictor();
        want_magic0 = MAGIC_FIRST_RST;
        want_magic1 = MAGIC_SECOND_RST;
        want_strict = 1'b0;
        byte_count  = '0;
        crc_run     = CRC_INIT;
    endtask

    // Works out the result word, if any, that one accepted byte causes.
    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic [31:0] pos;
        logic        is_payload;
        logic [7:0]  comp;
        pos = byte_count;
        is_payload = (pos >= HDR_BYTES);
        if (is_payload) begin
            crc_run = crc_step(crc_run, b);
        end else begin
            hdr_seen[pos[HDR_IDX_W-1:0]] = b;
        end
        if (byte_count != 32'hFFFFFFFF) begin
            byte_count++;
        end
        if (!is_payload && !last) begin
            return;
        end
        r = '0;
        if (is_payload) begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
        end
        if (last) begin
            r.frame_done = 1'b1;
            if (byte_count < HDR_BYTES) begin
                // A frame cut inside the header reports no header fields.
                r.frame_status = ST_SHORT;
            end else begin
                comp          = hdr_seen[OFS_COMP];
                r.msg_kind    = hdr_be16(OFS_KIND);
                r.msg_number  = hdr_be32(OFS_NUMBER);
                r.hdr_version = hdr_be16(OFS_VERSION);
                r.hdr_flags   = hdr_be32(OFS_FLAGS);
                r.hdr_content = hdr_seen[OFS_CONTENT];
                if (hdr_seen[OFS_MAGIC0] != want_magic0 || hdr_seen[OFS_MAGIC1] != want_magic1) begin
                    r.frame_status = ST_MAGIC;
                end else if (byte_count == 32'hFFFFFFFF ||
                             byte_count - HDR_BYTES != hdr_be32(OFS_LENGTH)) begin
                    r.frame_status = ST_LENGTH;
                end else if ((crc_run ^ CRC_XOUT) != hdr_be32(OFS_CRC)) begin
                    r.frame_status = ST_CRC;
                end else if (want_strict && comp > COMP_ON) begin
                    r.frame_status = ST_FLAG;
                end else if (comp == COMP_ON) begin
                    r.frame_status = ST_COMP;
                end else begin
                    r.frame_status = ST_OK;
                end
            end
            byte_count = '0;
            crc_run    = CRC_INIT;
        end
        pending_results = {pending_results, r};
    endtask

    // Sends one byte after a random gap; valid stays high on return.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_frame_byte(b, last);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // Waits until every predicted word has come out and the block is quiet.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; the channel valid is left high for back-to-back writes.
    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_MAGIC_FIRST:  want_magic0 = data;
            CFG_MAGIC_SECOND: want_magic1 = data;
            CFG_STRICT_FLAG:  want_strict = data[0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] fill_word(input t_fill fill);
        case (fill)
            FILL_ZERO: return 32'h0;
            FILL_ONES: return 32'hFFFFFFFF;
            default:   return $urandom;
        endcase
    endfunction

    task automatic push_be(input logic [31:0] v, input int unsigned nbytes);
        for (int i = nbytes - 1; i >= 0; i--) begin
            frame_q = {frame_q, v[i*8 +: 8]};
        end
    endtask

    // Builds one frame into frame_q. For a short frame n is the number of
    // bytes kept, for noise the total length, otherwise the payload length.
    task automatic make_frame(input t_frame_kind fk, input int unsigned n,
                              input t_fill fill, input bit crc_bad_too);
        logic [7:0]  pay [$];
        logic [31:0] pay_crc;
        logic [31:0] pay_len;
        logic [31:0] spoil;
        logic [7:0]  comp;
        logic [7:0]  m0;
        logic [7:0]  m1;
        int unsigned sel;
        frame_q.delete();
        if (fk == FK_NOISE) begin
            repeat (n) frame_q = {frame_q, 8'($urandom)};
            return;
        end
        if (fk != FK_SHORT) begin
            repeat (n) pay = {pay, 8'(fill_word(fill))};
        end
        pay_crc = CRC_INIT;
        foreach (pay[i]) begin
            pay_crc = crc_step(pay_crc, pay[i]);
        end
        pay_crc ^= CRC_XOUT;
        pay_len = pay.size();
        spoil = (fill == FILL_ONES) ? 32'hFFFFFFFF :
                (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
        case (fk)
            FK_COMP_ON:  comp = COMP_ON;
            FK_COMP_ODD: comp = (fill == FILL_ONES) ? 8'hFF : 8'($urandom_range(2, 255));
            default:     comp = COMP_NONE;
        endcase
        if (fk == FK_LENGTH) begin
            pay_len ^= spoil;
        end
        if (fk == FK_CRC || crc_bad_too) begin
            pay_crc ^= spoil;
        end
        m0 = want_magic0;
        m1 = want_magic1;
        if (fk == FK_MAGIC) begin
            // Spoil the first byte, the second, or both.
            sel = $urandom_range(0, 2);
            if (sel != 1) m0 ^= 8'($urandom_range(1, 255));
            if (sel != 0) m1 ^= 8'($urandom_range(1, 255));
        end
        frame_q = {frame_q, m0};
        frame_q = {frame_q, m1};
        push_be(fill_word(fill), 2);
        push_be(fill_word(fill), 4);
        push_be(fill_word(fill), 2);
        push_be(fill_word(fill), 4);
        push_be(fill_word(fill), 1);
        frame_q = {frame_q, comp};
        push_be(fill_word(fill), 4);
        push_be(pay_crc, 4);
        push_be(pay_len, 4);
        if (fk == FK_SHORT) begin
            while (frame_q.size() > n) frame_q.pop_back();
        end
        foreach (pay[i]) frame_q = {frame_q, pay[i]};
    endtask

    task automatic run_frame(input t_frame_kind fk, input int unsigned n,
                             input t_fill fill, input bit crc_bad_too);
        make_frame(fk, n, fill, crc_bad_too);
        send_frame();
    endtask

    // Reset values of the registers: default magic, flag check off.
    task automatic test_reset_defaults();
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        run_frame(FK_GOOD, 4, FILL_RANDOM, 1'b0);
        run_frame(FK_COMP_ODD, 2, FILL_RANDOM, 1'b0);
        wait_drained();
    endtask

    // Every status code but ST_FLAG, field extremes and the status priority order.
    task automatic test_status_codes();
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        run_frame(FK_SHORT, 1, FILL_RANDOM, 1'b0);
        run_frame(FK_SHORT, HDR_BYTES - 1, FILL_RANDOM, 1'b0);
        run_frame(FK_GOOD, 0, FILL_ZERO, 1'b0);
        run_frame(FK_GOOD, 3, FILL_ZERO, 1'b0);
        run_frame(FK_COMP_ODD, 3, FILL_ONES, 1'b0);
        run_frame(FK_MAGIC, 2, FILL_RANDOM, 1'b1);
        run_frame(FK_LENGTH, 2, FILL_ONES, 1'b1);
        run_frame(FK_CRC, 5, FILL_RANDOM, 1'b0);
        run_frame(FK_CRC, 0, FILL_RANDOM, 1'b0);
        run_frame(FK_COMP_ON, 2, FILL_RANDOM, 1'b0);
        run_frame(FK_COMP_ON, 2, FILL_RANDOM, 1'b1);
        wait_drained();
    endtask

    // Strict mode rejects odd compressed flags, but only after the CRC check.
    task automatic test_strict_flag();
        cfg_write(CFG_STRICT_FLAG, 8'h01);
        cfg_release();
        tx_fast = 1'b1;
        rx_fast = 1'b0;
        run_frame(FK_COMP_ODD, 2, FILL_ONES, 1'b0);
        run_frame(FK_COMP_ODD, 1, FILL_RANDOM, 1'b1);
        run_frame(FK_COMP_ON, 1, FILL_RANDOM, 1'b0);
        run_frame(FK_GOOD, 1, FILL_RANDOM, 1'b0);
        wait_drained();
        // Only bit 0 of the write data counts.
        cfg_write(CFG_STRICT_FLAG, 8'hFE);
        cfg_release();
        run_frame(FK_COMP_ODD, 1, FILL_RANDOM, 1'b0);
        wait_drained();
    endtask

    // Magic registers at both extremes, and a write to the unused index.
    task automatic test_magic_registers();
        tx_fast = 1'b0;
        rx_fast = 1'b1;
        cfg_write(CFG_MAGIC_FIRST, 8'h00);
        cfg_write(CFG_MAGIC_SECOND, 8'h00);
        cfg_release();
        run_frame(FK_GOOD, 1, FILL_RANDOM, 1'b0);
        run_frame(FK_MAGIC, 1, FILL_RANDOM, 1'b0);
        wait_drained();
        cfg_write(CFG_MAGIC_FIRST, 8'hFF);
        cfg_write(CFG_MAGIC_SECOND, 8'hFF);
        cfg_write(CFG_IDX_UNUSED, 8'($urandom));
        cfg_release();
        run_frame(FK_GOOD, 1, FILL_RANDOM, 1'b0);
        run_frame(FK_MAGIC, 1, FILL_RANDOM, 1'b0);
        wait_drained();
    endtask

    function automatic logic [7:0] pick_magic(input logic [7:0] dflt);
        case ($urandom_range(0, 3))
            0:       return dflt;
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic set_random_config();
        cfg_write(CFG_MAGIC_FIRST, pick_magic(MAGIC_FIRST_RST));
        cfg_write(CFG_MAGIC_SECOND, pick_magic(MAGIC_SECOND_RST));
        cfg_write(CFG_STRICT_FLAG, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_IDX_UNUSED, 8'($urandom));
        end
        cfg_release();
    endtask

    // Mostly well-formed frames with random content, plus errors and noise.
    task automatic test_random_traffic();
        int unsigned pick;
        int unsigned n;
        t_frame_kind fk;
        bit          crc_bad_too;
        while (items_sent < ITEM_TARGET) begin
            set_random_config();
            repeat ($urandom_range(4, 12)) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      fk = FK_GOOD;
                else if (pick < 55) fk = FK_COMP_ON;
                else if (pick < 63) fk = FK_COMP_ODD;
                else if (pick < 70) fk = FK_MAGIC;
                else if (pick < 77) fk = FK_LENGTH;
                else if (pick < 84) fk = FK_CRC;
                else if (pick < 92) fk = FK_SHORT;
                else                fk = FK_NOISE;
                if (fk == FK_SHORT) begin
                    n = $urandom_range(1, HDR_BYTES - 1);
                end else if (fk == FK_NOISE) begin
                    n = $urandom_range(1, 60);
                end else if ($urandom_range(0, 15) == 0) begin
                    n = $urandom_range(25, 200);
                end else begin
                    n = $urandom_range(0, 24);
                end
                crc_bad_too = (fk != FK_GOOD && fk != FK_CRC) && ($urandom_range(0, 3) == 0);
                tx_fast = ($urandom_range(0, 3) == 0);
                rx_fast = ($urandom_range(0, 3) == 0);
                run_frame(fk, n, FILL_RANDOM, crc_bad_too);
            end
            wait_drained();
        end
    endtask

    // Result side: random stall before each word, then compare with the oldest prediction.
    initial begin
        int unsigned stall;
        t_result     want;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word 0x%0h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                check_field("payload_valid", 32'(m_axis_tuser), 32'(want.payload_valid));
                check_field("frame_done", 32'(m_axis_tlast), 32'(want.frame_done));
                check_field("payload_byte", 32'(m_axis_tdata[7:0]),
                            32'(want.payload_byte));
                check_field("frame_status", 32'(m_axis_tdata[10:8]),
                            32'(want.frame_status));
                check_field("msg_kind", 32'(m_axis_tdata[26:11]), 32'(want.msg_kind));
                check_field("msg_number", m_axis_tdata[58:27], want.msg_number);
                check_field("hdr_version", 32'(m_axis_tdata[74:59]),
                            32'(want.hdr_version));
                check_field("hdr_flags", m_axis_tdata[106:75], want.hdr_flags);
                check_field("hdr_content", 32'(m_axis_tdata[114:107]),
                            32'(want.hdr_content));
                check_field("pad bits", 32'(m_axis_tdata[119:115]), 32'h0);
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_MAGIC_FIRST;
        i_cfg_data    <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        tx_fast        = 1'b0;
        rx_fast        = 1'b0;
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_status_codes();
        test_strict_flag();
        test_magic_registers();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("** crc_checked_frame_deframer: PASSED **");
        end else begin
            $display("** crc_checked_frame_deframer: FAILED **");
        end
        $finish;
    end

endmodule
